### hdl/set_assoc_cache_hit_miss_classifier_top_macros.svh
// Assertion helpers for the cache classifier RTL.
`ifndef SET_ASSOC_CACHE_HIT_MISS_CLASSIFIER_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_HIT_MISS_CLASSIFIER_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SACC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cache classifier assertion failed");

// Clocked assertion that is also checked during reset.
`define SACC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cache classifier assertion failed");

`endif

### hdl/sacc_pkg.sv
`timescale 1ns / 1ps
package sacc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] CFG_POLICY      = 2'd2;

  // Replacement policies. The spare code behaves as LRU.
  localparam logic [1:0] POL_LRU   = 2'd0;
  localparam logic [1:0] POL_FIFO  = 2'd1;
  localparam logic [1:0] POL_RAND  = 2'd2;
  localparam logic [1:0] POL_SPARE = 2'd3;

  // Outcome codes.
  localparam logic [1:0] OUT_HIT        = 2'd0;
  localparam logic [1:0] OUT_COMPULSORY = 2'd1;
  localparam logic [1:0] OUT_CAPACITY   = 2'd2;
  localparam logic [1:0] OUT_CONFLICT   = 2'd3;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_e;

endpackage

### hdl/set_assoc_cache_hit_miss_classifier_top.sv
`timescale 1ns / 1ps
// Set-associative cache hit/miss classifier. Each address transfer is split
// into offset, set index and tag, looked up in one row of the set memory and
// classified as hit, compulsory, capacity or conflict miss, with saturating
// running totals. The set row is first read from the synchronous set memory
// into registers; then, in S_LOOK, the tags are compared, the ranks updated and
// the row written back, which waits while a stalled result is still held. The
// next item is taken in the cycle after write back, not before it.
// After reset the line valid memory is cleared one set per cycle, and the input
// stalls until the clearing pass has covered all 2^SET_BITS sets (256 by default).
module set_assoc_cache_hit_miss_classifier_top
  import sacc_pkg::*;
#(
  parameter int SET_BITS = 8,
  parameter int WAYS     = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic [1:0]  way_used_o,
  output logic [31:0] hits_total_o,
  output logic [31:0] misses_total_o,
  output logic [31:0] compulsory_total_o,
  output logic [31:0] capacity_total_o,
  output logic [31:0] conflict_total_o
);

`include "set_assoc_cache_hit_miss_classifier_top_macros.svh"

  localparam int NUM_SETS  = 1 << SET_BITS;
  localparam int NUM_LINES = NUM_SETS * WAYS;
  localparam int SW        = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WW        = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LW        = $clog2(NUM_LINES + 1);
  localparam logic [63:0] RECIP64 = ((64'd1 << 32) + 64'(WAYS) - 64'd1) / 64'(WAYS);
  localparam logic [32:0] RECIP   = RECIP64[32:0];

  // Configuration registers.
  logic [4:0] off_q;
  logic [3:0] idx_q;
  logic [1:0] pol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= 5'd2;
      idx_q <= 4'd8;
      pol_q <= POL_LRU;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OFFSET_BITS: off_q <= cfg_data_i;
        CFG_INDEX_BITS:  idx_q <= cfg_data_i[3:0];
        CFG_POLICY:      pol_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Effective index width and address split.
  logic [3:0]  ib;
  logic [5:0]  tag_shift;
  logic [31:0] addr_shr;
  logic [SW-1:0] set_d;
  logic [31:0]   tag_d;

  always_comb begin
    ib        = (32'(idx_q) > SET_BITS) ? 4'(SET_BITS) : idx_q;
    tag_shift = 6'(off_q) + 6'(ib);
    addr_shr  = address_i >> off_q;
    set_d     = SW'(addr_shr) & SW'((32'd1 << ib) - 32'd1);
    tag_d     = (tag_shift >= 6'd32) ? 32'd0 : (address_i >> tag_shift);
  end

  // Clearing pass over the line valid memory after reset.
  logic          clr_busy_q;
  logic [SW-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + SW'(1);
      if (clr_idx_q == SW'(NUM_SETS - 1)) clr_busy_q <= 1'b0;
    end
  end

  // Control.
  state_e state_q, state_d;
  logic   accept_in, commit;
  logic   out_valid_q;

  assign in_stall_o  = (state_q != S_IDLE) || clr_busy_q;
  assign accept_in   = in_valid_i && !in_stall_o;
  assign commit      = (state_q == S_LOOK) && !(out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept_in) state_d = S_LOOK;
      S_LOOK: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Captured item.
  logic [SW-1:0] set_q;
  logic [31:0]   tag_q;

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
  end

  // Set memory: tags and both rank vectors of one set in a row.
  logic [WAYS-1:0][31:0]   tag_mem [NUM_SETS];
  logic [WAYS-1:0][WW-1:0] rec_mem [NUM_SETS];
  logic [WAYS-1:0][WW-1:0] fil_mem [NUM_SETS];
  logic [WAYS-1:0][31:0]   rd_tag_q;
  logic [WAYS-1:0][WW-1:0] rd_rec_q;
  logic [WAYS-1:0][WW-1:0] rd_fil_q;
  logic [WAYS-1:0][31:0]   wr_tag;
  logic [WAYS-1:0][WW-1:0] wr_rec;
  logic [WAYS-1:0][WW-1:0] wr_fil;

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      rd_tag_q <= tag_mem[set_d];
      rd_rec_q <= rec_mem[set_d];
      rd_fil_q <= fil_mem[set_d];
    end
    if (commit) begin
      tag_mem[set_q] <= wr_tag;
      rec_mem[set_q] <= wr_rec;
      fil_mem[set_q] <= wr_fil;
    end
  end

  // Line valid memory, one row per set, zeroed by the clearing pass.
  logic [WAYS-1:0] valid_mem [NUM_SETS];
  logic [WAYS-1:0] rd_valid_q;
  logic [WAYS-1:0] wr_valid;

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      rd_valid_q <= valid_mem[set_d];
    end
    if (clr_busy_q) begin
      valid_mem[clr_idx_q] <= '0;
    end else if (commit) begin
      valid_mem[set_q] <= wr_valid;
    end
  end

  // Random victim: the next LFSR value modulo WAYS by reciprocal multiply.
  logic [15:0] lfsr_q;
  logic [15:0] lfsr_nxt;
  logic [48:0] recip_prod;
  logic [31:0] frac_q;
  logic [37:0] rem_prod;
  logic [WW-1:0] rand_way;

  assign lfsr_nxt   = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
  assign recip_prod = 49'(lfsr_nxt) * 49'(RECIP);
  assign rem_prod   = 38'(frac_q) * 38'(WAYS);
  assign rand_way   = WW'(rem_prod[37:32]);

  always_ff @(posedge clk_i) begin
    frac_q <= recip_prod[31:0];
  end

  // Lookup, victim choice and rank update.
  logic          hit, empty, rand_evict;
  logic [WW-1:0] hit_way, empty_way, lru_way, fifo_way, way;
  logic [1:0]    outcome;
  logic [LW-1:0] filled_q;
  logic [LW-1:0] full_thr;

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    empty     = 1'b0;
    empty_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (rd_valid_q[i] && rd_tag_q[i] == tag_q) begin
        hit     = 1'b1;
        hit_way = WW'(i);
      end
      if (!rd_valid_q[i]) begin
        empty     = 1'b1;
        empty_way = WW'(i);
      end
    end
    lru_way  = '0;
    fifo_way = '0;
    for (int i = 1; i < WAYS; i++) begin
      if (rd_rec_q[i] >= rd_rec_q[lru_way]) lru_way = WW'(i);
      if (rd_fil_q[i] >= rd_fil_q[fifo_way]) fifo_way = WW'(i);
    end
    full_thr   = LW'(WAYS) << ib;
    rand_evict = 1'b0;
    if (hit) begin
      way     = hit_way;
      outcome = OUT_HIT;
    end else if (empty) begin
      way     = empty_way;
      outcome = OUT_COMPULSORY;
    end else begin
      case (pol_q)
        POL_FIFO: way = fifo_way;
        POL_RAND: begin
          way        = rand_way;
          rand_evict = 1'b1;
        end
        default:  way = lru_way;
      endcase
      outcome = (filled_q >= full_thr) ? OUT_CAPACITY : OUT_CONFLICT;
    end
  end

  // Row write-back: touched way to rank zero; valid ways more recent than it age.
  always_comb begin
    wr_tag   = rd_tag_q;
    wr_rec   = rd_rec_q;
    wr_fil   = rd_fil_q;
    wr_valid = rd_valid_q;
    for (int i = 0; i < WAYS; i++) begin
      if (WW'(i) != way && rd_valid_q[i]) begin
        if (!hit && empty) begin
          wr_rec[i] = rd_rec_q[i] + WW'(1);
          wr_fil[i] = rd_fil_q[i] + WW'(1);
        end else begin
          if (rd_rec_q[i] < rd_rec_q[way]) wr_rec[i] = rd_rec_q[i] + WW'(1);
          if (!hit && rd_fil_q[i] < rd_fil_q[way]) wr_fil[i] = rd_fil_q[i] + WW'(1);
        end
      end
    end
    wr_rec[way] = '0;
    if (!hit) begin
      wr_fil[way]   = '0;
      wr_tag[way]   = tag_q;
      wr_valid[way] = 1'b1;
    end
  end

  // Fill count, LFSR and running totals.
  logic [31:0] hits_q, miss_q, comp_q, cap_q, conf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
      lfsr_q   <= LFSR_SEED;
      hits_q   <= '0;
      miss_q   <= '0;
      comp_q   <= '0;
      cap_q    <= '0;
      conf_q   <= '0;
    end else if (commit) begin
      if (rand_evict) lfsr_q <= lfsr_nxt;
      if (outcome == OUT_HIT) begin
        if (hits_q != '1) hits_q <= hits_q + 32'd1;
      end else begin
        if (miss_q != '1) miss_q <= miss_q + 32'd1;
      end
      if (outcome == OUT_COMPULSORY) begin
        filled_q <= filled_q + LW'(1);
        if (comp_q != '1) comp_q <= comp_q + 32'd1;
      end
      if (outcome == OUT_CAPACITY && cap_q != '1) cap_q <= cap_q + 32'd1;
      if (outcome == OUT_CONFLICT && conf_q != '1) conf_q <= conf_q + 32'd1;
    end
  end

  assign hits_total_o       = hits_q;
  assign misses_total_o     = miss_q;
  assign compulsory_total_o = comp_q;
  assign capacity_total_o   = cap_q;
  assign conflict_total_o   = conf_q;

  // Output register: holds the result until its transfer.
  logic [1:0] outcome_q, way_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      outcome_q  <= outcome;
      way_used_q <= 2'(way);
    end
  end

  assign outcome_o  = outcome_q;
  assign way_used_o = way_used_q;

  // Checks.
  `SACC_ASSERT(a_accept_to_look, accept_in |=> state_q == S_LOOK)
  `SACC_ASSERT(a_commit_shows_result, commit |=> out_valid_o)
  `SACC_ASSERT(a_fill_bounded, filled_q <= LW'(NUM_LINES))
  `SACC_ASSERT(a_no_accept_while_clearing, clr_busy_q |-> !accept_in)

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import sacc_pkg::*;

  localparam int SET_BITS = 8;
  localparam int WAYS = 4;
  localparam int LINES = (1 << SET_BITS) * WAYS;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [1:0]  way_used;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] compulsory;
    logic [31:0] capacity;
    logic [31:0] conflict;
  } access_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  outcome_o;
  logic [1:0]  way_used_o;
  logic [31:0] hits_total_o;
  logic [31:0] misses_total_o;
  logic [31:0] compulsory_total_o;
  logic [31:0] capacity_total_o;
  logic [31:0] conflict_total_o;

  set_assoc_cache_hit_miss_classifier_top #(
    .SET_BITS(SET_BITS),
    .WAYS    (WAYS)
  ) u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the cache: tags, valid bits, ranks, counters and configuration.
  logic [4:0]  cur_offset_bits = 5'd2;
  logic [3:0]  cur_index_bits = 4'd8;
  logic [1:0]  cur_policy = POL_LRU;
  logic [31:0] tag_mem[LINES];
  bit          line_vld[LINES];
  int          recency[LINES];
  int          fill_order[LINES];
  int unsigned filled_lines = 0;
  logic [15:0] lfsr_q = LFSR_SEED;
  logic [31:0] hit_cnt = 0, miss_cnt = 0, comp_cnt = 0, cap_cnt = 0, confl_cnt = 0;

  access_result_t expected_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  logic [31:0] addr_pool[8];

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Move a way to rank 0 and age the valid ways that were more recent than it (all valid ways if it was not valid).
  function automatic void promote_recency(int base, int w, bit was_valid);
    int old;
    old = recency[base + w];
    for (int i = 0; i < WAYS; i++)
      if (i != w && line_vld[base + i] && (!was_valid || recency[base + i] < old))
        recency[base + i]++;
    recency[base + w] = 0;
  endfunction

  function automatic void promote_fill(int base, int w, bit was_valid);
    int old;
    old = fill_order[base + w];
    for (int i = 0; i < WAYS; i++)
      if (i != w && line_vld[base + i] && (!was_valid || fill_order[base + i] < old))
        fill_order[base + i]++;
    fill_order[base + w] = 0;
  endfunction

  function automatic access_result_t classify_access(logic [31:0] addr);
    access_result_t r;
    int ib, shift, set_idx, base, way, best;
    logic [31:0] tag;
    bit hit, empty;
    ib = (cur_index_bits > SET_BITS) ? SET_BITS : cur_index_bits;
    shift = cur_offset_bits + ib;
    tag = (shift >= 32) ? 32'd0 : addr >> shift;
    set_idx = (addr >> cur_offset_bits) & ((1 << ib) - 1);
    base = set_idx * WAYS;
    hit = 0;
    empty = 0;
    way = 0;
    r.outcome = OUT_HIT;
    for (int w = 0; w < WAYS; w++)
      if (!hit && line_vld[base + w] && tag_mem[base + w] == tag) begin
        hit = 1;
        way = w;
      end
    if (hit) begin
      hit_cnt = sat_inc(hit_cnt);
      promote_recency(base, way, 1);
    end else begin
      miss_cnt = sat_inc(miss_cnt);
      for (int w = 0; w < WAYS; w++)
        if (!empty && !line_vld[base + w]) begin
          empty = 1;
          way = w;
        end
      if (empty) begin
        promote_recency(base, way, 0);
        promote_fill(base, way, 0);
        line_vld[base + way] = 1;
        tag_mem[base + way] = tag;
        filled_lines++;
        comp_cnt = sat_inc(comp_cnt);
        r.outcome = OUT_COMPULSORY;
      end else begin
        if (cur_policy == POL_RAND) begin
          lfsr_q = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
          way = lfsr_q % WAYS;
        end else begin
          // Oldest rank wins; ties go to the highest way.
          best = 0;
          for (int i = 1; i < WAYS; i++)
            if (cur_policy == POL_FIFO ? fill_order[base + i] >= fill_order[base + best]
                                       : recency[base + i] >= recency[base + best])
              best = i;
          way = best;
        end
        promote_recency(base, way, 1);
        promote_fill(base, way, 1);
        tag_mem[base + way] = tag;
        if (filled_lines >= (1 << ib) * WAYS) begin
          cap_cnt = sat_inc(cap_cnt);
          r.outcome = OUT_CAPACITY;
        end else begin
          confl_cnt = sat_inc(confl_cnt);
          r.outcome = OUT_CONFLICT;
        end
      end
    end
    r.way_used = way[1:0];
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    r.compulsory = comp_cnt;
    r.capacity = cap_cnt;
    r.conflict = confl_cnt;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result-side back-pressure: runs of free flow, short stalls and a few long ones.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 60) begin
      out_stall_i <= 1'b0;
      stall_left <= $urandom_range(1, 20);
    end else begin
      out_stall_i <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                : $urandom_range(0, 2);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    access_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (outcome_o !== e.outcome) begin
          $error("outcome: expected %0d, got %0d", e.outcome, outcome_o);
          errors++;
        end
        if (way_used_o !== e.way_used) begin
          $error("way_used: expected %0d, got %0d", e.way_used, way_used_o);
          errors++;
        end
        if (hits_total_o !== e.hits) begin
          $error("hits_total: expected %0d, got %0d", e.hits, hits_total_o);
          errors++;
        end
        if (misses_total_o !== e.misses) begin
          $error("misses_total: expected %0d, got %0d", e.misses, misses_total_o);
          errors++;
        end
        if (compulsory_total_o !== e.compulsory) begin
          $error("compulsory_total: expected %0d, got %0d", e.compulsory,
                 compulsory_total_o);
          errors++;
        end
        if (capacity_total_o !== e.capacity) begin
          $error("capacity_total: expected %0d, got %0d", e.capacity, capacity_total_o);
          errors++;
        end
        if (conflict_total_o !== e.conflict) begin
          $error("conflict_total: expected %0d, got %0d", e.conflict, conflict_total_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no transfer happens on any channel.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_access(logic [31:0] addr);
    int gap;
    in_valid_i <= 1'b1;
    address_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(classify_access(addr));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_OFFSET_BITS: cur_offset_bits = value;
      CFG_INDEX_BITS:  cur_index_bits = value[3:0];
      CFG_POLICY:      cur_policy = value[1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [4:0] off, logic [3:0] ib, logic [1:0] pol);
    write_reg(CFG_OFFSET_BITS, off);
    write_reg(CFG_INDEX_BITS, {1'b0, ib});
    write_reg(CFG_POLICY, {3'b0, pol});
  endtask

  // Addresses mostly come from a small pool so that hits and evictions dominate.
  function automatic logic [31:0] next_address();
    int p, k;
    p = $urandom_range(0, 99);
    k = $urandom_range(0, 7);
    if (p < 55) return addr_pool[k];
    if (p < 85) begin
      addr_pool[k] = addr_pool[$urandom_range(0, 7)] ^ (32'd1 << $urandom_range(0, 31));
      return addr_pool[k];
    end
    addr_pool[k] = $urandom;
    return addr_pool[k];
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
    repeat (count) send_access(next_address());
  endtask

  // Extremes of the address, hits, filling a tiny cache and a capacity eviction.
  task automatic test_directed_basic();
    configure(5'd0, 4'd0, POL_LRU);
    send_access(32'h0000_0000);
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'h0000_0001);
    send_access(32'h0000_0002);
    send_access(32'h0000_0000);
    send_access(32'h0000_0003);
    send_access(32'h8000_0000);
    send_access(32'hFFFF_FFFF);
  endtask

  // FIFO eviction in one set, random draws from the LFSR, and policy three.
  task automatic test_directed_policies();
    configure(5'd4, 4'd1, POL_FIFO);
    for (int i = 0; i < 5; i++) send_access(32'h100 * i);
    send_access(32'h0);
    send_access(32'h600);
    configure(5'd4, 4'd1, POL_RAND);
    send_access(32'h700);
    send_access(32'h800);
    write_reg(CFG_POLICY, {3'b0, POL_SPARE});
    send_access(32'h900);
  endtask

  // Index wider than the set memory and tag shifts of 32 or more.
  task automatic test_directed_shifts();
    configure(5'd31, 4'd15, POL_LRU);
    send_access(32'h8000_0000);
    send_access(32'h0000_0000);
    send_access(32'h7FFF_FFFF);
    configure(5'd24, 4'd8, POL_FIFO);
    send_access(32'hFF00_0000);
    send_access(32'h1234_5678);
  endtask

  task automatic test_random_sweep();
    configure(5'd2, 4'd0, POL_LRU);
    run_random(200);
    configure(5'd0, 4'd2, POL_FIFO);
    run_random(200);
    configure(5'd3, 4'd3, POL_RAND);
    run_random(250);
    configure(5'd16, 4'd8, POL_LRU);
    run_random(200);
    configure(5'd1, 4'd1, POL_SPARE);
    run_random(150);
    configure(5'd31, 4'd9, POL_RAND);
    run_random(100);
    configure(5'd5, 4'd4, POL_FIFO);
    run_random(200);
  endtask

  // Back-to-back traffic with no idling, then a pause until all results are in, then spaced traffic with another pause.
  task automatic test_drain_pause();
    configure(5'd2, 4'd2, POL_LRU);
    quiet = 1'b1;
    run_random(150);
    quiet = 1'b0;
    drain();
    run_random(150);
    drain();
    run_random(250);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_basic();
    test_directed_policies();
    test_directed_shifts();
    test_random_sweep();
    test_drain_pause();
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
